// ===== sv/ist_pkg.sv =====
// shared constants and types for the integer set store
`default_nettype none
package ist_pkg;

  localparam int unsigned CAPACITY_DEF = 64;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  localparam logic [STATUS_W-1:0] STS_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] STS_NOCHANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STS_FULL     = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } ist_state_t;

endpackage
`default_nettype wire

// ===== sv/ist_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none
module ist_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/integer_set_store_top.sv =====
// set of distinct signed integers kept in one ram, scanned per transaction
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid, in_ready, in_operation,       | to block
//          | in_value                                |
//  out     | out_valid, out_ready, out_status,       | from block
//          | out_was_member, out_greater_count,      |
//          | out_less_count, out_size_after          |
//
// the single ram read port is walked once over all stored entries, one per cycle, and a
// transaction is finished before the next one is accepted.
// rst_n empties the set at once; ram contents are left as they are.
// a finished result waits in the output register; the next transaction is
// accepted and scanned meanwhile, and its ram write-back and result wait for out_ready.
`default_nettype none
module integer_set_store_top
  import ist_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [OP_W-1:0]       in_operation,
  input  wire logic signed [VALUE_W-1:0] in_value,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [STATUS_W-1:0]        out_status,
  output logic                       out_was_member,
  output logic [COUNT_W-1:0]         out_greater_count,
  output logic [COUNT_W-1:0]         out_less_count,
  output logic [COUNT_W-1:0]         out_size_after
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  ist_state_t state_r, state_nxt;

  logic [CW-1:0]             count_r;
  logic [OP_W-1:0]           op_r;
  logic signed [VALUE_W-1:0] value_r;
  logic [CW-1:0]             n_r;
  logic [CW-1:0]             idx_r;
  logic                      rd_vld_r;
  logic [CW-1:0]             rd_idx_r;
  logic [CW-1:0]             gt_r;
  logic [CW-1:0]             lt_r;
  logic                      member_r;
  logic [AW-1:0]             pos_r;
  logic signed [VALUE_W-1:0] last_r;

  logic                      out_valid_r;
  logic [STATUS_W-1:0]       out_status_r;
  logic                      out_member_r;
  logic [COUNT_W-1:0]        out_gt_r;
  logic [COUNT_W-1:0]        out_lt_r;
  logic [COUNT_W-1:0]        out_size_r;

  logic                      in_fire;
  logic                      issue;
  logic                      finish;
  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [VALUE_W-1:0]        ram_wdata;
  logic [VALUE_W-1:0]        ram_rdata;
  logic signed [VALUE_W-1:0] rd_value;
  logic [STATUS_W-1:0]       status_nxt;
  logic [CW-1:0]             size_nxt;

  ist_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_value = $signed(ram_rdata);
  assign in_fire  = in_valid && in_ready;
  assign issue    = (state_r == ST_SCAN) && (idx_r < n_r);
  assign finish   = (state_r == ST_FINISH) && (!out_valid_r || out_ready);

  // fsm and write-back decision
  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    status_nxt = STS_DONE;
    size_nxt   = n_r;
    ram_we     = 1'b0;
    ram_waddr  = pos_r;
    ram_wdata  = last_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx_r == n_r && !rd_vld_r) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        priority if (op_r == OP_INSERT) begin
          priority if (member_r) begin
            status_nxt = STS_NOCHANGE;
          end else if (n_r >= CAP_C) begin
            status_nxt = STS_FULL;
          end else begin
            ram_we    = finish;
            ram_waddr = n_r[AW-1:0];
            ram_wdata = value_r;
            size_nxt  = n_r + 1'b1;
          end
        end else if (op_r == OP_DELETE) begin
          if (!member_r) begin
            status_nxt = STS_NOCHANGE;
          end else begin
            // last entry moves into the hole
            ram_we   = finish;
            size_nxt = n_r - 1'b1;
          end
        end else begin
          status_nxt = STS_DONE;
        end
        if (finish) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= issue;
      if (finish) begin
        count_r     <= size_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // scan datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r     <= in_operation;
      value_r  <= in_value;
      n_r      <= count_r;
      idx_r    <= '0;
      gt_r     <= '0;
      lt_r     <= '0;
      member_r <= 1'b0;
      pos_r    <= '0;
    end else begin
      if (issue) begin
        idx_r <= idx_r + 1'b1;
      end
      rd_idx_r <= idx_r;
      if (rd_vld_r) begin
        last_r <= rd_value;
        if (rd_value > value_r) begin
          gt_r <= gt_r + 1'b1;
        end else if (rd_value < value_r) begin
          lt_r <= lt_r + 1'b1;
        end else if (!member_r) begin
          member_r <= 1'b1;
          pos_r    <= rd_idx_r[AW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_status_r <= status_nxt;
      out_member_r <= member_r;
      out_gt_r     <= COUNT_W'(gt_r);
      out_lt_r     <= COUNT_W'(lt_r);
      out_size_r   <= COUNT_W'(size_nxt);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_was_member    = out_member_r;
  assign out_greater_count = out_gt_r;
  assign out_less_count    = out_lt_r;
  assign out_size_after    = out_size_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("stored count above capacity");

  a_tally_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FINISH |-> ({1'b0, gt_r} + {1'b0, lt_r} + (CW+1)'(member_r)) == {1'b0, n_r})
    else $error("scan tallies do not account for every stored entry");

  a_read_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> rd_idx_r < n_r)
    else $error("ram read beyond stored entries");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    finish && status_nxt != STS_DONE |=> count_r == $past(count_r))
    else $error("count changed on a refused transaction");
`endif

endmodule
`default_nettype wire

// ===== dv/integer_set_store_top_tb.sv =====
// testbench for the integer set store: directed and random transactions checked against a set model
module integer_set_store_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ist_pkg::*;

  localparam int unsigned CAP = CAPACITY_DEF;
  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned SETTLE_CYCLES = CAP + 8;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                was_member;
    logic [COUNT_W-1:0]  greater;
    logic [COUNT_W-1:0]  less;
    logic [COUNT_W-1:0]  size_after;
  } set_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [OP_W-1:0] in_operation;
  logic signed [VALUE_W-1:0] in_value;
  logic out_valid;
  logic out_ready;
  logic [STATUS_W-1:0] out_status;
  logic out_was_member;
  logic [COUNT_W-1:0] out_greater_count;
  logic [COUNT_W-1:0] out_less_count;
  logic [COUNT_W-1:0] out_size_after;

  // set model: values kept in insertion order, closed up on delete
  logic signed [VALUE_W-1:0] set_vals [CAP];
  int unsigned set_count = 0;

  set_result_t pending_results [$];
  int unsigned error_count = 0;
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles = 0;

  integer_set_store_top #(
    .CAPACITY(CAP)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_was_member   (out_was_member),
    .out_greater_count(out_greater_count),
    .out_less_count   (out_less_count),
    .out_size_after   (out_size_after)
  );

  always #6 clk = ~clk;

  function automatic set_result_t set_apply(logic [OP_W-1:0] op,
                                            logic signed [VALUE_W-1:0] v);
    set_result_t r;
    int unsigned greater;
    int unsigned less;
    int unsigned hit_pos;
    bit hit;
    greater = 0;
    less = 0;
    hit_pos = 0;
    hit = 1'b0;
    r.status = STS_DONE;
    for (int unsigned i = 0; i < set_count; i++) begin
      if (set_vals[i] > v) greater++;
      else if (set_vals[i] < v) less++;
      else if (!hit) begin
        hit = 1'b1;
        hit_pos = i;
      end
    end
    if (op == OP_INSERT) begin
      if (hit) r.status = STS_NOCHANGE;
      else if (set_count >= CAP) r.status = STS_FULL;
      else begin
        set_vals[set_count] = v;
        set_count++;
      end
    end else if (op == OP_DELETE) begin
      if (!hit) r.status = STS_NOCHANGE;
      else begin
        for (int unsigned i = hit_pos; i + 1 < set_count; i++) set_vals[i] = set_vals[i + 1];
        set_count--;
      end
    end
    // any other code, the reserved one included, only looks
    r.was_member = hit;
    r.greater = greater[COUNT_W-1:0];
    r.less = less[COUNT_W-1:0];
    r.size_after = set_count[COUNT_W-1:0];
    return r;
  endfunction

  function automatic bit set_holds(logic signed [VALUE_W-1:0] v);
    for (int unsigned i = 0; i < set_count; i++) begin
      if (set_vals[i] == v) return 1'b1;
    end
    return 1'b0;
  endfunction

  // members, their neighbors, extremes and fully random words
  function automatic logic signed [VALUE_W-1:0] pick_value();
    int unsigned roll;
    logic signed [VALUE_W-1:0] v;
    roll = $urandom_range(0, 99);
    if (set_count != 0 && roll < 40) begin
      v = set_vals[$urandom_range(0, set_count - 1)];
    end else if (set_count != 0 && roll < 60) begin
      v = set_vals[$urandom_range(0, set_count - 1)];
      v = ($urandom_range(0, 1) != 0) ? v + 1 : v - 1;
    end else if (roll < 75) begin
      case ($urandom_range(0, 3))
        0: v = VAL_MIN;
        1: v = VAL_MAX;
        2: v = '0;
        default: v = '1;
      endcase
    end else begin
      v = $urandom();
    end
    return v;
  endfunction

  task automatic send_item(logic [OP_W-1:0] op, logic signed [VALUE_W-1:0] v);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(set_apply(op, v));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_item(OP_QUERY, VAL_MIN);
    send_item(OP_DELETE, '0);
    send_item(OP_INSERT, '0);
    send_item(OP_INSERT, VAL_MIN);
    send_item(OP_INSERT, VAL_MAX);
    send_item(OP_INSERT, '1);
    send_item(OP_INSERT, 32'sd1);
    send_item(OP_INSERT, '0);
    send_item(OP_QUERY, '0);
    send_item(OP_QUERY, 32'sd5);
    send_item(OP_RESERVED, VAL_MAX);
    send_item(OP_RESERVED, 32'sd12345);
    send_item(OP_DELETE, 32'sd7);
    send_item(OP_DELETE, VAL_MAX);
    send_item(OP_QUERY, VAL_MAX);
    send_item(OP_DELETE, VAL_MIN);
    send_item(OP_QUERY, VAL_MIN);
    send_item(OP_INSERT, VAL_MAX);
    send_item(OP_INSERT, 32'sh5555_5555);
    send_item(OP_INSERT, 32'shaaaa_aaaa);
    send_item(OP_QUERY, 32'sh5555_5554);
    send_item(OP_DELETE, '1);
  endtask

  task automatic test_fill_overflow();
    logic signed [VALUE_W-1:0] v;
    while (set_count < CAP) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(OP_QUERY, pick_value());
      end else begin
        v = $urandom();
        if (!set_holds(v)) send_item(OP_INSERT, v);
      end
    end
    do v = $urandom(); while (set_holds(v));
    // refused on a full set, then a present value on a full set
    send_item(OP_INSERT, v);
    send_item(OP_INSERT, set_vals[$urandom_range(0, CAP - 1)]);
    send_item(OP_QUERY, v);
    send_item(OP_RESERVED, set_vals[0]);
    send_item(OP_DELETE, set_vals[$urandom_range(0, CAP - 1)]);
    send_item(OP_INSERT, v);
    send_item(OP_INSERT, VAL_MIN);
  endtask

  task automatic test_random(int unsigned n);
    int unsigned roll;
    logic [OP_W-1:0] op;
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (roll < 50) op = OP_INSERT;
      else if (roll < 80) op = OP_DELETE;
      else if (roll < 96) op = OP_QUERY;
      else op = OP_RESERVED;
      send_item(op, pick_value());
    end
  endtask

  task automatic test_empty_out();
    int unsigned roll;
    while (set_count != 0) begin
      roll = $urandom_range(0, 99);
      if (roll < 80) send_item(OP_DELETE, set_vals[$urandom_range(0, set_count - 1)]);
      else if (roll < 90) send_item(OP_DELETE, pick_value());
      else send_item(OP_QUERY, pick_value());
    end
    send_item(OP_QUERY, pick_value());
    send_item(OP_DELETE, VAL_MAX);
    send_item(OP_INSERT, pick_value());
  endtask

  always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

  always @(posedge clk) begin : check_results
    set_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: result with no transaction pending: status %0d member %0d gt %0d lt %0d size %0d",
                 $time, out_status, out_was_member, out_greater_count, out_less_count,
                 out_size_after);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status || out_was_member !== want.was_member ||
            out_greater_count !== want.greater || out_less_count !== want.less ||
            out_size_after !== want.size_after) begin
          error_count++;
          $display("%0t: expected status %0d member %0d gt %0d lt %0d size %0d, got %0d %0d %0d %0d %0d",
                   $time, want.status, want.was_member, want.greater, want.less, want.size_after,
                   out_status, out_was_member, out_greater_count, out_less_count,
                   out_size_after);
        end
      end
    end
  end

  // ends the run if no transaction moves on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = OP_QUERY;
    in_value = '0;
    out_ready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_gap_pct = 35;
    recv_stall_pct = 50;
    test_directed();
    test_fill_overflow();
    test_random(80);

    send_gap_pct = 50;
    recv_stall_pct = 35;
    test_random(80);
    test_empty_out();

    send_gap_pct = 0;
    recv_stall_pct = 0;
    test_fill_overflow();
    test_random(50);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/ist_pkg.sv
sv/ist_ram.sv
sv/integer_set_store_top.sv
dv/integer_set_store_top_tb.sv
